// ===== sv/flash_read_request_splitter_macros.svh =====
// Assertion macros for the flash read request splitter checker.
// Depends on nothing; included by the files that assert.
`ifndef FLASH_READ_REQUEST_SPLITTER_MACROS_SVH
`define FLASH_READ_REQUEST_SPLITTER_MACROS_SVH

// Implication in the same cycle.
`define FRS_ASSERT_SAME(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("frs assertion failed");

// Implication in the following cycle.
`define FRS_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("frs assertion failed");

`endif

// ===== sv/frs_pkg.sv =====
// Shared types, widths and defaults of the flash read request splitter.
// Depends on nothing; used by every module of the block.
package frs_pkg;

  localparam int OFS_W      = 32;
  localparam int REQ_W      = 25;
  localparam int ADDR_W     = 32;
  localparam int SECS_W     = 12;
  localparam int SKIP_W     = 9;
  localparam int DEST_W     = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_CMDS   = 18;

  localparam int SECTOR_BYTES_DEF      = 512;
  localparam int BURST_BYTES_DEF       = 1 * 1024 * 1024;
  localparam int MAX_REQUEST_BYTES_DEF = 16 * 1024 * 1024;
  localparam int NOR_BYTES_DEF         = 16 * 1024 * 1024;

  localparam logic [CFG_DATA_W-1:0] DEV_SECTORS_RESET = 32'h0189_3000;

  typedef enum logic [1:0] {
    CMD_NOR    = 2'd0,
    CMD_PART   = 2'd1,
    CMD_DIRECT = 2'd2,
    CMD_ERR    = 2'd3
  } cmd_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLASH_IS_EMMC       = 1'b0,
    REG_DEVICE_SECTOR_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAP,
    ST_DECIDE,
    ST_DIV_OFS,
    ST_HEAD,
    ST_DIV_LEFT,
    ST_COUNT,
    ST_ROUTE,
    ST_EMIT_ERR,
    ST_EMIT_NOR,
    ST_EMIT_HEAD,
    ST_EMIT_BURST,
    ST_EMIT_TAIL
  } state_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ERR,
    EM_NOR,
    EM_HEAD,
    EM_BURST,
    EM_TAIL
  } emit_t;

  typedef enum logic {
    DIV_OFFSET,
    DIV_LEFT
  } div_sel_t;

  typedef struct packed {
    logic [OFS_W-1:0] start_offset;
    logic [REQ_W-1:0] request_bytes;
  } frs_in_t;

  typedef struct packed {
    cmd_kind_t         cmd_kind;
    logic [ADDR_W-1:0] flash_address;
    logic [SECS_W-1:0] sectors_to_read;
    logic [SKIP_W-1:0] skip_bytes;
    logic [REQ_W-1:0]  byte_count;
    logic [DEST_W-1:0] dest_offset;
    logic              last;
  } frs_out_t;

  typedef struct packed {
    logic     load;
    logic     cap_calc;
    logic     div_start;
    div_sel_t div_sel;
    logic     head_calc;
    logic     count_calc;
    emit_t    emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emmc;
    logic zero;
    logic oversize;
    logic nor_bad;
    logic cap_bad;
    logic div_done;
    logic has_head;
    logic head_only;
    logic full_zero;
    logic rem_zero;
    logic count_bad;
    logic burst_final;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ===== sv/frs_sec_div.sv =====
// Sector split of a byte address: sector index and offset within the sector, registered.
// Depends on frs_pkg for the address width; the sector size is a power of two.
module frs_sec_div #(
  parameter int SECTOR_BYTES = frs_pkg::SECTOR_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [frs_pkg::ADDR_W-1:0]      dividend,
  output logic                            done,
  output logic [frs_pkg::ADDR_W-1:0]      quotient,
  output logic [$clog2(SECTOR_BYTES)-1:0] remainder
);

  localparam int SEC_W = $clog2(SECTOR_BYTES);

  logic                       done_r, done_nxt;
  logic [frs_pkg::ADDR_W-1:0] q_r, q_nxt;
  logic [SEC_W-1:0]           r_r, r_nxt;

  always_comb begin
    done_nxt = start;
    q_nxt    = q_r;
    r_nxt    = r_r;
    if (start) begin
      q_nxt = dividend >> SEC_W;
      r_nxt = dividend[SEC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;

endmodule

// ===== sv/frs_ctrl.sv =====
// Controller state machine of the flash read request splitter.
// Depends on frs_pkg for the state, command and status types.
module frs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  frs_pkg::ctrl_sts_t sts,
  output frs_pkg::ctrl_cmd_t cmd
);

  frs_pkg::state_t state_r, state_nxt;

  assign in_stall = state_r != frs_pkg::ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frs_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = frs_pkg::ST_CAP;
      end
      frs_pkg::ST_CAP: begin
        state_nxt = frs_pkg::ST_DECIDE;
      end
      frs_pkg::ST_DECIDE: begin
        if (sts.zero) state_nxt = frs_pkg::ST_IDLE;
        else if (sts.oversize) state_nxt = frs_pkg::ST_EMIT_ERR;
        else if (!sts.emmc) begin
          state_nxt = sts.nor_bad ? frs_pkg::ST_EMIT_ERR : frs_pkg::ST_EMIT_NOR;
        end else begin
          state_nxt = sts.cap_bad ? frs_pkg::ST_EMIT_ERR : frs_pkg::ST_DIV_OFS;
        end
      end
      frs_pkg::ST_DIV_OFS: begin
        if (sts.div_done) state_nxt = frs_pkg::ST_HEAD;
      end
      frs_pkg::ST_HEAD: begin
        state_nxt = frs_pkg::ST_DIV_LEFT;
      end
      frs_pkg::ST_DIV_LEFT: begin
        if (sts.div_done) state_nxt = frs_pkg::ST_COUNT;
      end
      frs_pkg::ST_COUNT: begin
        state_nxt = frs_pkg::ST_ROUTE;
      end
      frs_pkg::ST_ROUTE: begin
        if (sts.count_bad) state_nxt = frs_pkg::ST_EMIT_ERR;
        else if (sts.has_head) state_nxt = frs_pkg::ST_EMIT_HEAD;
        else if (!sts.full_zero) state_nxt = frs_pkg::ST_EMIT_BURST;
        else state_nxt = frs_pkg::ST_EMIT_TAIL;
      end
      frs_pkg::ST_EMIT_ERR, frs_pkg::ST_EMIT_NOR, frs_pkg::ST_EMIT_TAIL: begin
        if (sts.out_free) state_nxt = frs_pkg::ST_IDLE;
      end
      frs_pkg::ST_EMIT_HEAD: begin
        if (sts.out_free) begin
          if (sts.head_only) state_nxt = frs_pkg::ST_IDLE;
          else if (!sts.full_zero) state_nxt = frs_pkg::ST_EMIT_BURST;
          else state_nxt = frs_pkg::ST_EMIT_TAIL;
        end
      end
      frs_pkg::ST_EMIT_BURST: begin
        if (sts.out_free && sts.burst_final) begin
          state_nxt = sts.rem_zero ? frs_pkg::ST_IDLE : frs_pkg::ST_EMIT_TAIL;
        end
      end
      default: state_nxt = frs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.emit = frs_pkg::EM_NONE;
    cmd.div_sel = frs_pkg::DIV_OFFSET;
    unique case (state_r)
      frs_pkg::ST_IDLE:   cmd.load = in_valid;
      frs_pkg::ST_CAP:    cmd.cap_calc = 1'b1;
      frs_pkg::ST_DECIDE: begin
        cmd.div_start = !sts.zero && !sts.oversize && sts.emmc && !sts.cap_bad;
      end
      frs_pkg::ST_DIV_OFS, frs_pkg::ST_DIV_LEFT, frs_pkg::ST_ROUTE: begin
      end
      frs_pkg::ST_HEAD: begin
        cmd.head_calc = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = frs_pkg::DIV_LEFT;
      end
      frs_pkg::ST_COUNT: cmd.count_calc = 1'b1;
      frs_pkg::ST_EMIT_ERR: begin
        if (sts.out_free) cmd.emit = frs_pkg::EM_ERR;
      end
      frs_pkg::ST_EMIT_NOR: begin
        if (sts.out_free) cmd.emit = frs_pkg::EM_NOR;
      end
      frs_pkg::ST_EMIT_HEAD: begin
        if (sts.out_free) cmd.emit = frs_pkg::EM_HEAD;
      end
      frs_pkg::ST_EMIT_BURST: begin
        if (sts.out_free) cmd.emit = frs_pkg::EM_BURST;
      end
      frs_pkg::ST_EMIT_TAIL: begin
        if (sts.out_free) cmd.emit = frs_pkg::EM_TAIL;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/frs_datapath.sv =====
// Datapath: configuration registers, range checks, sector walk and output register.
// Depends on frs_pkg and instantiates frs_sec_div.
module frs_datapath #(
  parameter int SECTOR_BYTES      = frs_pkg::SECTOR_BYTES_DEF,
  parameter int BURST_BYTES       = frs_pkg::BURST_BYTES_DEF,
  parameter int MAX_REQUEST_BYTES = frs_pkg::MAX_REQUEST_BYTES_DEF,
  parameter int NOR_BYTES         = frs_pkg::NOR_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [frs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  frs_pkg::frs_in_t               in_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output frs_pkg::frs_out_t              out_data,
  input  frs_pkg::ctrl_cmd_t             cmd,
  output frs_pkg::ctrl_sts_t             sts
);

  localparam int SEC_W  = $clog2(SECTOR_BYTES);
  localparam int SUM_W  = frs_pkg::ADDR_W + 1;
  localparam int CAP_W  = frs_pkg::CFG_DATA_W + SEC_W + 1;
  localparam int REQ_W  = frs_pkg::REQ_W;
  localparam int BS     = (BURST_BYTES % SECTOR_BYTES == 0) ? BURST_BYTES / SECTOR_BYTES : 1;
  localparam logic [31:0] LIM0 = 32'(frs_pkg::MAX_CMDS * BS);
  localparam logic [31:0] LIM1 = 32'((frs_pkg::MAX_CMDS - 1) * BS);
  localparam logic [31:0] LIM2 = 32'((frs_pkg::MAX_CMDS - 2) * BS);

  logic                           emmc_r;
  logic [frs_pkg::CFG_DATA_W-1:0] dev_sectors_r;

  logic [frs_pkg::OFS_W-1:0]  ofs_r;
  logic [REQ_W-1:0]           size_r;
  logic [SUM_W-1:0]           sum_r;
  logic [CAP_W-1:0]           cap_r;
  logic [frs_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  logic [SEC_W-1:0]           skip_r;
  logic                       has_head_r;
  logic [REQ_W-1:0]           head_bytes_r;
  logic [REQ_W-1:0]           left_r;
  logic [REQ_W-1:0]           left_secs_r, left_secs_nxt;
  logic [SEC_W-1:0]           rem_r;
  logic [frs_pkg::DEST_W-1:0] dest_r, dest_nxt;

  logic                       out_valid_r;
  frs_pkg::frs_out_t          out_data_r, out_data_nxt;
  logic                       out_free;
  logic                       out_load;

  logic                       div_done;
  logic [frs_pkg::ADDR_W-1:0] div_q;
  logic [SEC_W-1:0]           div_rem;
  logic [frs_pkg::ADDR_W-1:0] div_dividend;

  logic [SEC_W:0]             room;
  logic [REQ_W-1:0]           part;
  logic                       has_head_c;
  logic [REQ_W-1:0]           left_c;
  logic [REQ_W-1:0]           b_secs;
  logic [REQ_W-1:0]           b_bytes;
  logic                       burst_final;
  logic [31:0]                lim;

  assign room       = (SEC_W+1)'(SECTOR_BYTES) - {1'b0, div_rem};
  assign part       = (REQ_W'(room) < size_r) ? REQ_W'(room) : size_r;
  assign has_head_c = div_rem != '0;
  assign left_c     = has_head_c ? size_r - part : size_r;

  assign div_dividend = (cmd.div_sel == frs_pkg::DIV_LEFT) ?
                        frs_pkg::ADDR_W'(left_c) : ofs_r;

  frs_sec_div #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_rem)
  );

  assign burst_final = left_secs_r <= REQ_W'(BS);
  assign b_secs      = burst_final ? left_secs_r : REQ_W'(BS);
  assign b_bytes     = REQ_W'(b_secs * SECTOR_BYTES);

  always_comb begin
    case ({has_head_r, rem_r != '0})
      2'b00:   lim = LIM0;
      2'b11:   lim = LIM2;
      default: lim = LIM1;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = cmd.emit != frs_pkg::EM_NONE;

  always_comb begin
    out_data_nxt          = '0;
    out_data_nxt.cmd_kind = frs_pkg::CMD_ERR;
    idx_nxt               = idx_r;
    dest_nxt              = dest_r;
    left_secs_nxt         = left_secs_r;
    case (cmd.emit)
      frs_pkg::EM_ERR: begin
        out_data_nxt.last = 1'b1;
      end
      frs_pkg::EM_NOR: begin
        out_data_nxt.cmd_kind      = frs_pkg::CMD_NOR;
        out_data_nxt.flash_address = ofs_r;
        out_data_nxt.byte_count    = size_r;
        out_data_nxt.last          = 1'b1;
      end
      frs_pkg::EM_HEAD: begin
        out_data_nxt.cmd_kind        = frs_pkg::CMD_PART;
        out_data_nxt.flash_address   = idx_r;
        out_data_nxt.sectors_to_read = frs_pkg::SECS_W'(1);
        out_data_nxt.skip_bytes      = frs_pkg::SKIP_W'(skip_r);
        out_data_nxt.byte_count      = head_bytes_r;
        out_data_nxt.dest_offset     = dest_r;
        out_data_nxt.last            = left_r == '0;
        idx_nxt  = idx_r + 1'b1;
        dest_nxt = dest_r + frs_pkg::DEST_W'(head_bytes_r);
      end
      frs_pkg::EM_BURST: begin
        out_data_nxt.cmd_kind        = frs_pkg::CMD_DIRECT;
        out_data_nxt.flash_address   = idx_r;
        out_data_nxt.sectors_to_read = frs_pkg::SECS_W'(b_secs);
        out_data_nxt.byte_count      = b_bytes;
        out_data_nxt.dest_offset     = dest_r;
        out_data_nxt.last            = burst_final && (rem_r == '0);
        idx_nxt       = idx_r + frs_pkg::ADDR_W'(b_secs);
        dest_nxt      = dest_r + frs_pkg::DEST_W'(b_bytes);
        left_secs_nxt = left_secs_r - b_secs;
      end
      frs_pkg::EM_TAIL: begin
        out_data_nxt.cmd_kind        = frs_pkg::CMD_PART;
        out_data_nxt.flash_address   = idx_r;
        out_data_nxt.sectors_to_read = frs_pkg::SECS_W'(1);
        out_data_nxt.byte_count      = REQ_W'(rem_r);
        out_data_nxt.dest_offset     = dest_r;
        out_data_nxt.last            = 1'b1;
      end
      default: out_data_nxt.cmd_kind = frs_pkg::CMD_ERR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emmc_r        <= 1'b0;
      dev_sectors_r <= frs_pkg::DEV_SECTORS_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          frs_pkg::REG_FLASH_IS_EMMC:       emmc_r <= cfg_data[0];
          frs_pkg::REG_DEVICE_SECTOR_COUNT: dev_sectors_r <= cfg_data;
          default: emmc_r <= emmc_r;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end

    if (cmd.load) begin
      ofs_r  <= in_data.start_offset;
      size_r <= in_data.request_bytes;
      dest_r <= '0;
    end else begin
      dest_r <= dest_nxt;
    end
    if (cmd.cap_calc) begin
      sum_r <= SUM_W'(ofs_r) + SUM_W'(size_r);
      cap_r <= CAP_W'(dev_sectors_r) * CAP_W'(SECTOR_BYTES);
    end
    if (cmd.head_calc) begin
      idx_r        <= div_q;
      skip_r       <= div_rem;
      has_head_r   <= has_head_c;
      head_bytes_r <= part;
      left_r       <= left_c;
    end else begin
      idx_r <= idx_nxt;
    end
    if (cmd.count_calc) begin
      left_secs_r <= div_q[REQ_W-1:0];
      rem_r       <= div_rem;
    end else begin
      left_secs_r <= left_secs_nxt;
    end
    if (out_load) out_data_r <= out_data_nxt;
  end

  assign sts.emmc        = emmc_r;
  assign sts.zero        = size_r == '0;
  assign sts.oversize    = size_r > REQ_W'(MAX_REQUEST_BYTES);
  assign sts.nor_bad     = sum_r >= SUM_W'(NOR_BYTES);
  assign sts.cap_bad     = CAP_W'(sum_r) > cap_r;
  assign sts.div_done    = div_done;
  assign sts.has_head    = has_head_r;
  assign sts.head_only   = left_r == '0;
  assign sts.full_zero   = left_secs_r == '0;
  assign sts.rem_zero    = rem_r == '0;
  assign sts.count_bad   = 32'(left_secs_r) > lim;
  assign sts.burst_final = burst_final;
  assign sts.out_free    = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sv/flash_read_request_splitter.sv =====
// NOR copies and range errors found at the decision reach the output register after the capture
// and decide states; eMMC commands follow the two sector splits and the command count.
// Throughput: commands leave one per cycle while the output is not stalled; a request is taken
// only while the controller is idle, once the previous request is finished.
// Reset: synchronous, active low; it idles the controller, empties the output register and
// returns the configuration registers to their defaults.
module flash_read_request_splitter #(
  parameter int SECTOR_BYTES      = frs_pkg::SECTOR_BYTES_DEF,
  parameter int BURST_BYTES       = frs_pkg::BURST_BYTES_DEF,
  parameter int MAX_REQUEST_BYTES = frs_pkg::MAX_REQUEST_BYTES_DEF,
  parameter int NOR_BYTES         = frs_pkg::NOR_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  frs_pkg::frs_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output frs_pkg::frs_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frs_pkg::CFG_DATA_W-1:0] cfg_data
);

  frs_pkg::ctrl_cmd_t cmd;
  frs_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  frs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  frs_datapath #(
    .SECTOR_BYTES     (SECTOR_BYTES),
    .BURST_BYTES      (BURST_BYTES),
    .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES),
    .NOR_BYTES        (NOR_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== sv/frs_checker.sv =====
// Port-level checker of the flash read request splitter, bound to the top level.
// Depends on frs_pkg and the assertion macros header.
`include "flash_read_request_splitter_macros.svh"

module frs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input frs_pkg::frs_out_t out_data
);

  // A stalled result beat holds.
  `FRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_data))
  // The block works on one request at a time.
  `FRS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // An error is a single empty final command.
  `FRS_ASSERT_SAME(a_err_form, clk, rst_n,
                   out_valid && out_data.cmd_kind == frs_pkg::CMD_ERR,
                   out_data.last && out_data.byte_count == '0)
  // A NOR copy is one final command with no sectors.
  `FRS_ASSERT_SAME(a_nor_form, clk, rst_n,
                   out_valid && out_data.cmd_kind == frs_pkg::CMD_NOR,
                   out_data.last && out_data.sectors_to_read == '0)

endmodule

bind flash_read_request_splitter frs_checker u_frs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
